[hw/rtl/rsa_pkg.sv]
`timescale 1ns / 1ps
package rsa_pkg;
	localparam int SampleWidth = 32;
	localparam int FracBits = 16;
	localparam int TotalWidth = 48;
	localparam int CountWidth = 32;
	localparam int M2Width = 63;
	localparam int DivWidth = 64;
	localparam int DivSteps = DivWidth;
	localparam int StepWidth = 7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV_MEAN,
		ST_MUL,
		ST_DIV_VAR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic first;
		logic prep;
		logic div_start_mean;
		logic div_start_var;
		logic mean_done;
		logic mul_step;
		logic var_done;
	} cmd_t;

	typedef struct packed {
		logic first_sample;
		logic div_busy;
		logic mul_done;
	} status_t;
endpackage

[hw/rtl/rsa_divider.sv]
`timescale 1ns / 1ps
module rsa_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rsa_pkg::DivWidth-1:0] dividend,
	input  logic [rsa_pkg::CountWidth-1:0] divisor,
	output logic                       busy,
	output logic [rsa_pkg::DivWidth-1:0] quotient
);
	import rsa_pkg::*;

	logic [DivWidth-1:0]   quo_q;
	logic [CountWidth:0]   rem_q;
	logic [CountWidth-1:0] dsr_q;
	logic [StepWidth-1:0]  cnt_q;
	logic [CountWidth:0]   trial;
	logic [CountWidth:0]   diff;

	assign trial = {rem_q[CountWidth-1:0], quo_q[DivWidth-1]};
	assign diff = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy <= 1'b0;
		end else if (start) begin
			cnt_q <= StepWidth'(DivSteps);
			busy <= 1'b1;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == StepWidth'(1)) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy) begin
			if (!diff[CountWidth]) begin
				rem_q <= diff;
				quo_q <= {quo_q[DivWidth-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[DivWidth-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

[hw/rtl/rsa_datapath.sv]
`timescale 1ns / 1ps
module rsa_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rsa_pkg::cmd_t                  cmd,
	output rsa_pkg::status_t               status,
	input  logic [rsa_pkg::SampleWidth-1:0] sample,
	output logic [rsa_pkg::CountWidth-1:0] sample_count,
	output logic [rsa_pkg::SampleWidth-1:0] mean,
	output logic [rsa_pkg::M2Width-1:0]    variance,
	output logic                           variance_valid,
	output logic [rsa_pkg::SampleWidth-1:0] minimum,
	output logic [rsa_pkg::SampleWidth-1:0] maximum,
	output logic [rsa_pkg::TotalWidth-1:0] total,
	output logic [rsa_pkg::SampleWidth-1:0] latest
);
	import rsa_pkg::*;

	localparam int MagW = SampleWidth + 1;
	localparam logic signed [TotalWidth:0] SumHi = {2'b00, {(TotalWidth-1){1'b1}}};
	localparam logic signed [TotalWidth:0] SumLo = {2'b11, {(TotalWidth-1){1'b0}}};

	logic signed [SampleWidth-1:0] x_q, mean_q, min_q, max_q, last_q;
	logic [CountWidth-1:0]         count_q;
	logic signed [TotalWidth-1:0]  sum_q;
	logic [M2Width-1:0]            m2_q, var_q;
	logic                          neg_q;
	logic [MagW-1:0]               dmag_q, vmag_q;
	logic [2*MagW-1:0]             prod_q;
	logic [1:0]                    mcnt_q;
	logic                          div_start;
	logic [DivWidth-1:0]           div_in, quo;
	logic [CountWidth-1:0]         div_den;
	logic                          div_busy;

	logic signed [SampleWidth:0]   delta, dev;
	logic signed [TotalWidth:0]    sum_ext;
	logic signed [SampleWidth:0]   step;
	logic signed [SampleWidth-1:0] new_mean;
	logic [2*MagW-1:0]             pp;
	logic [2*MagW-FracBits-1:0]    term;
	logic [M2Width:0]              m2_sum;
	logic [M2Width-1:0]            term_sat;
	logic [MagW-1:0]               dmag_d;
	logic [CountWidth-1:0]         count_inc;

	assign delta = {x_q[SampleWidth-1], x_q} - {mean_q[SampleWidth-1], mean_q};
	assign dmag_d = delta[SampleWidth] ? MagW'(-delta) : MagW'(delta);
	assign count_inc = (count_q != {CountWidth{1'b1}}) ? count_q + 1'b1 : count_q;
	assign step = neg_q ? -$signed({1'b0, quo[SampleWidth-1:0]})
		: $signed({1'b0, quo[SampleWidth-1:0]});
	assign new_mean = SampleWidth'(mean_q + step);
	assign dev = {x_q[SampleWidth-1], x_q} - {new_mean[SampleWidth-1], new_mean};
	assign sum_ext = {sum_q[TotalWidth-1], sum_q} + (TotalWidth+1)'(x_q);
	assign pp = (2*MagW)'(dmag_q[MagW/2-1:0] * vmag_q) << 0;
	assign term = prod_q[2*MagW-1:FracBits];
	assign term_sat = (term > (2*MagW-FracBits)'({M2Width{1'b1}})) ? {M2Width{1'b1}}
		: M2Width'(term);
	assign m2_sum = {1'b0, m2_q} + {1'b0, term_sat};

	assign div_start = cmd.div_start_mean | cmd.div_start_var;
	assign div_in = cmd.div_start_mean ? DivWidth'(dmag_d) : DivWidth'(m2_q);
	assign div_den = cmd.div_start_mean ? count_inc : count_q - 1'b1;

	rsa_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_in),
		.divisor(div_den), .busy(div_busy), .quotient(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mean_q <= '0;
			m2_q <= '0;
			var_q <= '0;
			min_q <= '0;
			max_q <= '0;
			sum_q <= '0;
			last_q <= '0;
			mcnt_q <= '0;
			x_q <= '0;
			neg_q <= 1'b0;
			dmag_q <= '0;
			vmag_q <= '0;
			prod_q <= '0;
		end else begin
			if (cmd.load) begin
				x_q <= $signed(sample);
				last_q <= $signed(sample);
			end
			if (cmd.first) begin
				count_q <= CountWidth'(1);
				mean_q <= x_q;
				min_q <= x_q;
				max_q <= x_q;
				sum_q <= TotalWidth'(x_q);
				m2_q <= '0;
			end
			if (cmd.prep) begin
				count_q <= count_inc;
				if (sum_ext > SumHi)
					sum_q <= SumHi[TotalWidth-1:0];
				else if (sum_ext < SumLo)
					sum_q <= SumLo[TotalWidth-1:0];
				else
					sum_q <= TotalWidth'(sum_ext);
				if (x_q < min_q) min_q <= x_q;
				if (x_q > max_q) max_q <= x_q;
				neg_q <= delta[SampleWidth];
				dmag_q <= dmag_d;
			end
			if (cmd.mean_done) begin
				mean_q <= new_mean;
				vmag_q <= dev[SampleWidth] ? MagW'(-dev) : MagW'(dev);
				prod_q <= '0;
				mcnt_q <= '0;
			end
			if (cmd.mul_step) begin
				mcnt_q <= mcnt_q + 1'b1;
				if (mcnt_q == 2'd0) prod_q <= pp;
				else if (mcnt_q == 2'd1)
					prod_q <= prod_q + ((2*MagW)'(dmag_q[MagW-1:MagW/2] * vmag_q) << (MagW/2));
				else if (mcnt_q == 2'd2)
					m2_q <= m2_sum[M2Width] ? {M2Width{1'b1}} : m2_sum[M2Width-1:0];
			end
			if (cmd.var_done) var_q <= quo[M2Width-1:0];
		end
	end

	assign status.first_sample = (count_q == '0);
	assign status.div_busy = div_busy;
	assign status.mul_done = (mcnt_q == 2'd3);

	assign sample_count = count_q;
	assign mean = mean_q;
	assign variance = var_q;
	assign variance_valid = (count_q >= CountWidth'(2));
	assign minimum = min_q;
	assign maximum = max_q;
	assign total = sum_q;
	assign latest = last_q;
endmodule

[hw/rtl/rsa_controller.sv]
`timescale 1ns / 1ps
module rsa_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  rsa_pkg::status_t status,
	output rsa_pkg::cmd_t    cmd
);
	import rsa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_PREP;
			ST_PREP: state_d = status.first_sample ? ST_DONE : ST_DIV_MEAN;
			ST_DIV_MEAN: if (!status.div_busy) state_d = ST_MUL;
			ST_MUL: if (status.mul_done) state_d = ST_DIV_VAR;
			ST_DIV_VAR: if (!status.div_busy) state_d = ST_DONE;
			ST_DONE: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_PREP: begin
				cmd.first = status.first_sample;
				cmd.prep = !status.first_sample;
				cmd.div_start_mean = !status.first_sample;
			end
			ST_DIV_MEAN: begin
				cmd.mean_done = !status.div_busy;
			end
			ST_MUL: begin
				cmd.mul_step = !status.mul_done;
				cmd.div_start_var = status.mul_done;
			end
			ST_DIV_VAR: begin
				cmd.var_done = !status.div_busy;
			end
			ST_DONE: out_valid = 1'b1;
			default: cmd = '0;
		endcase
	end
endmodule

[hw/rtl/running_stats_accumulator_top.sv]
`timescale 1ns / 1ps
// Channel  Handshake                 Beat
// input    in_valid / in_stall       sample
// output   out_valid / out_stall     sample_count .. latest
// Between input beats a sample passes through idle, setup, a pass of a 64-step
// radix-2 divider for the mean step, a multiply and accumulate, a second divider
// pass for the variance, and the result state.
// The first sample after reset passes only through idle, setup and result.
// Reset clears all statistics. A new sample is taken only once the result is taken.
module running_stats_accumulator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [rsa_pkg::SampleWidth-1:0] sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [rsa_pkg::CountWidth-1:0]  sample_count,
	output logic [rsa_pkg::SampleWidth-1:0] mean,
	output logic [rsa_pkg::M2Width-1:0]     variance,
	output logic                            variance_valid,
	output logic [rsa_pkg::SampleWidth-1:0] minimum,
	output logic [rsa_pkg::SampleWidth-1:0] maximum,
	output logic [rsa_pkg::TotalWidth-1:0]  total,
	output logic [rsa_pkg::SampleWidth-1:0] latest
);
	import rsa_pkg::*;

	cmd_t    cmd;
	status_t status;

	rsa_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
	);

	rsa_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status), .sample(sample),
		.sample_count(sample_count), .mean(mean), .variance(variance),
		.variance_valid(variance_valid), .minimum(minimum), .maximum(maximum),
		.total(total), .latest(latest)
	);
endmodule
